// ----- rtl/lrf_pkg.sv -----
// Shared types, constants and the fade table of the LED ring frame generator.
`default_nettype none

package lrf_pkg;

   localparam int TIME_W      = 32;
   localparam int COLOR_W     = 8;
   localparam int PIX_IDX_W   = 6;
   localparam int FADE_IDX_W  = 4;
   localparam int FADE_LEN    = 12;
   localparam int FADE_SHIFT  = 8;
   localparam int PRODUCT_W   = 2 * COLOR_W;

   localparam logic [TIME_W-1:0]  INTERVAL_RESET = 32'd50000;
   localparam logic [COLOR_W-1:0] COLOR_MAX      = 8'hff;
   localparam logic [COLOR_W-1:0] COLOR_ZERO     = 8'h00;

   // One frame request handed from the front end to the pixel engine.
   typedef struct packed {
      logic                 fail_mode;
      logic [COLOR_W-1:0]   base_red;
      logic [COLOR_W-1:0]   base_green;
      logic [COLOR_W-1:0]   base_blue;
      logic [PIX_IDX_W-1:0] rotation;
   } frame_cmd_type;

   // Queue handshake between front end, queue and pixel engine.
   typedef struct packed {
      logic push;
      logic full;
      logic valid;
      logic pop;
   } queue_ctl_type;

   function automatic logic [COLOR_W-1:0] fade_lookup(input logic [FADE_IDX_W-1:0] idx);
      logic [COLOR_W-1:0] f;
      case (idx)
         4'd4:    f = 8'd1;
         4'd5:    f = 8'd3;
         4'd6:    f = 8'd6;
         4'd7:    f = 8'd12;
         4'd8:    f = 8'd36;
         4'd9:    f = 8'd70;
         4'd10:   f = 8'd135;
         4'd11:   f = 8'd255;
         default: f = 8'd0;
      endcase
      return f;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/led_ring_fade_frame_generator.sv -----
// Top level of the LED ring fade frame generator.
`default_nettype none

// Each request is a time tick. The front end takes a tick, checks whether the
// frame interval has passed since the last frame (32-bit wrapping difference)
// and the link is idle, and if so queues one frame request and steps the
// rotation down. Up to two frame requests wait in the queue; while it is full,
// req_full is high. The pixel engine turns each frame request into PIXEL_COUNT
// pixel words, one per cycle while rsp_pop does not stall the output, through
// a factor stage and an output register, and the first word of a frame goes
// from the queue through these registers to the rsp ports. The pixel counter
// walks the pixels of a frame, and the engine pops a frame request only when
// it issues the last pixel of that frame. Ticks that cause no frame are taken
// at one per cycle while the queue has room. Cycle mode fades the base colour
// by the factor of stage (pixel + rotation) mod PIXEL_COUNT; pulse mode sends
// full red faded by the factor of the rotation stage, green and blue zero. The
// interval register is written over the csr port, which is always ready.
module led_ring_fade_frame_generator
   import lrf_pkg::*;
#(
   parameter int PIXEL_COUNT = 12
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // tick requests
   input  wire logic                 req_push,
   output logic                      req_full,
   input  wire logic [TIME_W-1:0]    req_now_us,
   input  wire logic                 req_link_busy,
   input  wire logic                 req_fail_mode,
   input  wire logic [COLOR_W-1:0]   req_base_red,
   input  wire logic [COLOR_W-1:0]   req_base_green,
   input  wire logic [COLOR_W-1:0]   req_base_blue,
   // pixel words
   output logic                      rsp_empty,
   input  wire logic                 rsp_pop,
   output logic [PIX_IDX_W-1:0]      rsp_pixel_number,
   output logic [COLOR_W-1:0]        rsp_out_green,
   output logic [COLOR_W-1:0]        rsp_out_red,
   output logic [COLOR_W-1:0]        rsp_out_blue,
   output logic                      rsp_last_pixel,
   // frame interval register
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [TIME_W-1:0]    csr_data
);

   queue_ctl_type queue_ctl;
   frame_cmd_type push_cmd;
   frame_cmd_type head_cmd;
   logic          queue_full;
   logic          queue_valid;
   logic          queue_push;
   logic          queue_pop;

   // hold the queue handshake together
   always_comb begin
      queue_ctl.push  = queue_push;
      queue_ctl.full  = queue_full;
      queue_ctl.valid = queue_valid;
      queue_ctl.pop   = queue_pop;
   end

   lrf_front #(
      .PIXEL_COUNT(PIXEL_COUNT)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_now_us     (req_now_us),
      .req_link_busy  (req_link_busy),
      .req_fail_mode  (req_fail_mode),
      .req_base_red   (req_base_red),
      .req_base_green (req_base_green),
      .req_base_blue  (req_base_blue),
      .csr_valid      (csr_valid),
      .csr_data       (csr_data),
      .queue_full     (queue_ctl.full),
      .req_full       (req_full),
      .csr_ready      (csr_ready),
      .queue_push     (queue_push),
      .queue_cmd      (push_cmd)
   );

   lrf_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .ctl_in   (queue_ctl),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .valid    (queue_valid),
      .head_cmd (head_cmd)
   );

   lrf_back #(
      .PIXEL_COUNT(PIXEL_COUNT)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (queue_ctl.valid),
      .cmd              (head_cmd),
      .cmd_pop          (queue_pop),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pixel_number (rsp_pixel_number),
      .rsp_out_green    (rsp_out_green),
      .rsp_out_red      (rsp_out_red),
      .rsp_out_blue     (rsp_out_blue),
      .rsp_last_pixel   (rsp_last_pixel)
   );

endmodule

`default_nettype wire

// ----- rtl/lrf_front.sv -----
// Front end: accepts time ticks, decides whether a frame is due, keeps frame timing state.
`default_nettype none

module lrf_front
   import lrf_pkg::*;
#(
   parameter int PIXEL_COUNT = 12
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_push,
   input  wire logic [TIME_W-1:0]    req_now_us,
   input  wire logic                 req_link_busy,
   input  wire logic                 req_fail_mode,
   input  wire logic [COLOR_W-1:0]   req_base_red,
   input  wire logic [COLOR_W-1:0]   req_base_green,
   input  wire logic [COLOR_W-1:0]   req_base_blue,
   input  wire logic                 csr_valid,
   input  wire logic [TIME_W-1:0]    csr_data,
   input  wire logic                 queue_full,
   output logic                      req_full,
   output logic                      csr_ready,
   output logic                      queue_push,
   output frame_cmd_type             queue_cmd
);

   logic [TIME_W-1:0]    interval_ff, interval_in;
   logic [TIME_W-1:0]    last_time_ff, last_time_in;
   logic [PIX_IDX_W-1:0] rotation_ff, rotation_in;
   logic [TIME_W-1:0]    elapsed;
   logic                 accept;
   logic                 fire;

   assign req_full  = queue_full;
   assign csr_ready = 1'b1;
   assign accept    = req_push && !queue_full;
   assign elapsed   = req_now_us - last_time_ff;
   assign fire      = accept && !req_link_busy && (elapsed >= interval_ff);

   assign queue_push           = fire;
   assign queue_cmd.fail_mode  = req_fail_mode;
   assign queue_cmd.base_red   = req_base_red;
   assign queue_cmd.base_green = req_base_green;
   assign queue_cmd.base_blue  = req_base_blue;
   assign queue_cmd.rotation   = rotation_ff;

   always_comb begin
      interval_in  = interval_ff;
      last_time_in = last_time_ff;
      rotation_in  = rotation_ff;
      if (csr_valid) begin
         interval_in = csr_data;
      end
      if (fire) begin
         last_time_in = req_now_us;
         // step rotation down, wrap to the top stage
         if (rotation_ff == '0) begin
            rotation_in = PIX_IDX_W'(PIXEL_COUNT - 1);
         end else begin
            rotation_in = rotation_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff  <= INTERVAL_RESET;
         last_time_ff <= '0;
         rotation_ff  <= '0;
      end else begin
         interval_ff  <= interval_in;
         last_time_ff <= last_time_in;
         rotation_ff  <= rotation_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/lrf_cmd_queue.sv -----
// Two-entry queue of frame requests between the front end and the pixel engine.
`default_nettype none

module lrf_cmd_queue
   import lrf_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire queue_ctl_type ctl_in,
   input  wire frame_cmd_type push_cmd,
   output logic               full,
   output logic               valid,
   output frame_cmd_type      head_cmd
);

   frame_cmd_type entry_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;
   logic          do_push;
   logic          do_pop;

   assign full     = (count_ff == 2'd2);
   assign valid    = (count_ff != 2'd0);
   assign head_cmd = entry_ff[rd_ptr_ff];
   assign do_push  = ctl_in.push && !full;
   assign do_pop   = ctl_in.pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/lrf_back.sv -----
// Pixel engine: walks the pixels of a frame, looks up the fade factor, scales the colour.
`default_nettype none

module lrf_back
   import lrf_pkg::*;
#(
   parameter int PIXEL_COUNT = 12
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 cmd_valid,
   input  wire frame_cmd_type        cmd,
   output logic                      cmd_pop,
   input  wire logic                 rsp_pop,
   output logic                      rsp_empty,
   output logic [PIX_IDX_W-1:0]      rsp_pixel_number,
   output logic [COLOR_W-1:0]        rsp_out_green,
   output logic [COLOR_W-1:0]        rsp_out_red,
   output logic [COLOR_W-1:0]        rsp_out_blue,
   output logic                      rsp_last_pixel
);

   localparam logic [PIX_IDX_W-1:0] LAST_IDX = PIX_IDX_W'(PIXEL_COUNT - 1);
   localparam logic [PIX_IDX_W:0]   COUNT_X  = (PIX_IDX_W+1)'(PIXEL_COUNT);
   localparam logic [PIX_IDX_W:0]   FADE_X   = (PIX_IDX_W+1)'(FADE_LEN);

   // pixel counter
   logic [PIX_IDX_W-1:0] pixel_ff, pixel_in;

   // factor stage
   logic                 s1_valid_ff, s1_valid_in;
   logic [COLOR_W-1:0]   s1_factor_ff;
   logic [COLOR_W-1:0]   s1_red_ff, s1_green_ff, s1_blue_ff;
   logic [PIX_IDX_W-1:0] s1_pixel_ff;
   logic                 s1_last_ff;

   // output register
   logic                 out_valid_ff, out_valid_in;
   logic [PIX_IDX_W-1:0] out_pixel_ff;
   logic [COLOR_W-1:0]   out_red_ff, out_green_ff, out_blue_ff;
   logic                 out_last_ff;

   logic                 out_free;
   logic                 s1_ready;
   logic                 issue;
   logic                 is_last;
   logic [PIX_IDX_W:0]   stage_sum;
   logic [PIX_IDX_W:0]   stage_wrap;
   logic [PIX_IDX_W:0]   stage_sel;
   logic [PIX_IDX_W:0]   fade_pos;
   logic [PIX_IDX_W:0]   fade_off;
   logic [COLOR_W-1:0]   factor;
   logic [PRODUCT_W-1:0] prod_red, prod_green, prod_blue;

   assign out_free = !out_valid_ff || rsp_pop;
   assign s1_ready = !s1_valid_ff || out_free;
   assign issue    = cmd_valid && s1_ready;
   assign is_last  = (pixel_ff == LAST_IDX);
   assign cmd_pop  = issue && is_last;

   // stage of this pixel: (pixel + rotation) mod count, or the rotation in pulse mode
   always_comb begin
      stage_sum = {1'b0, pixel_ff} + {1'b0, cmd.rotation};
      if (stage_sum >= COUNT_X) begin
         stage_wrap = stage_sum - COUNT_X;
      end else begin
         stage_wrap = stage_sum;
      end
      stage_sel = cmd.fail_mode ? {1'b0, cmd.rotation} : stage_wrap;
      // fade table sits at the top stages; stages below it get factor 0
      fade_pos = stage_sel + FADE_X;
      fade_off = fade_pos - COUNT_X;
      if (fade_pos < COUNT_X) begin
         factor = '0;
      end else begin
         factor = fade_lookup(fade_off[FADE_IDX_W-1:0]);
      end
   end

   always_comb begin
      pixel_in = pixel_ff;
      if (issue) begin
         pixel_in = is_last ? '0 : pixel_ff + 1'b1;
      end
      s1_valid_in = s1_valid_ff;
      if (s1_ready) begin
         s1_valid_in = issue;
      end
      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = s1_valid_ff;
      end
   end

   assign prod_red   = PRODUCT_W'(s1_factor_ff) * PRODUCT_W'(s1_red_ff);
   assign prod_green = PRODUCT_W'(s1_factor_ff) * PRODUCT_W'(s1_green_ff);
   assign prod_blue  = PRODUCT_W'(s1_factor_ff) * PRODUCT_W'(s1_blue_ff);

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_factor_ff <= factor;
         s1_red_ff    <= cmd.fail_mode ? COLOR_MAX : cmd.base_red;
         s1_green_ff  <= cmd.fail_mode ? COLOR_ZERO : cmd.base_green;
         s1_blue_ff   <= cmd.fail_mode ? COLOR_ZERO : cmd.base_blue;
         s1_pixel_ff  <= pixel_ff;
         s1_last_ff   <= is_last;
      end
      if (out_free && s1_valid_ff) begin
         out_pixel_ff <= s1_pixel_ff;
         out_red_ff   <= prod_red[FADE_SHIFT +: COLOR_W];
         out_green_ff <= prod_green[FADE_SHIFT +: COLOR_W];
         out_blue_ff  <= prod_blue[FADE_SHIFT +: COLOR_W];
         out_last_ff  <= s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pixel_ff     <= pixel_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_pixel_number = out_pixel_ff;
   assign rsp_out_green    = out_green_ff;
   assign rsp_out_red      = out_red_ff;
   assign rsp_out_blue     = out_blue_ff;
   assign rsp_last_pixel   = out_last_ff;

endmodule

`default_nettype wire
